// File: rtl/prid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prid_pkg
// shared types, codes and defaults of the palette run-length image decoder
// ----------------------------------------------------------------------------
package prid_pkg;

	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int MAX_WIDTH_DEF     = 1024;
	localparam int COORD_MAX         = 2047;
	localparam int QUEUE_DEPTH       = 4;
	localparam int INDEX_BITS_MAX    = 8;

	// request codes
	localparam logic [1:0] REQ_PALETTE = 2'd0;
	localparam logic [1:0] REQ_DATA    = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_INDEX_BITS   = 3'd2;
	localparam logic [2:0] CFG_MASKED       = 3'd3;
	localparam logic [2:0] CFG_ORIGIN_X     = 3'd4;
	localparam logic [2:0] CFG_ORIGIN_Y     = 3'd5;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  palette_index;
		logic [15:0] value;
	} req_t;

	typedef struct packed {
		logic [15:0] color;
		logic [10:0] pixel_x;
		logic [10:0] pixel_y;
		logic [15:0] run_length;
		logic        last;
	} span_t;

	typedef struct packed {
		logic [10:0] image_width;
		logic [3:0]  index_bits;
		logic        masked;
		logic [9:0]  origin_x;
		logic [9:0]  origin_y;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_PAL,
		OP_DATA,
		OP_RESTART
	} op_kind_t;

	// one classified request as it waits in the queue
	typedef struct packed {
		op_kind_t    kind;
		logic        packed_mode;
		logic        skip;
		logic [7:0]  idx0;
		logic [7:0]  idx1;
		logic [15:0] word;
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ1,
		BK_EMIT,
		BK_DIV
	} bk_state_t;

endpackage

// File: rtl/prid_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prid_front
// request intake: decodes request type and unpacks data words into ops
// ----------------------------------------------------------------------------
module prid_front (
	input  logic           clk,
	input  logic           arst_n,
	input  prid_pkg::cfg_t cfg,
	input  logic           req_valid,
	output logic           req_stall,
	input  prid_pkg::req_t req,
	output logic           push,
	output prid_pkg::op_t  op,
	input  logic           full
);

	logic          valid_s1;
	prid_pkg::op_t op_s1;
	prid_pkg::op_t op_d;
	logic          known;
	logic [3:0]    bits_eff;
	logic [15:0]   idx_mask;
	logic [7:0]    run_idx;
	logic [15:0]   run_len;
	logic          accept;

	assign req_stall = valid_s1 && full;
	assign accept    = req_valid && !req_stall;
	assign push      = valid_s1 && !full;
	assign op        = op_s1;

	always_comb begin
		bits_eff = (cfg.index_bits > 4'(prid_pkg::INDEX_BITS_MAX))
			? 4'(prid_pkg::INDEX_BITS_MAX) : cfg.index_bits;
		idx_mask = (16'd1 << bits_eff) - 16'd1;
		run_idx  = 8'(req.value & idx_mask);
		run_len  = (req.value >> bits_eff) + 16'd1;
		op_d     = '0;
		known    = 1'b1;
		unique case (req.req_type)
			prid_pkg::REQ_PALETTE: begin
				op_d.kind = prid_pkg::OP_PAL;
				op_d.idx0 = req.palette_index;
				op_d.word = req.value;
			end
			prid_pkg::REQ_DATA: begin
				op_d.kind        = prid_pkg::OP_DATA;
				op_d.packed_mode = (cfg.index_bits == 4'd0);
				op_d.idx0        = op_d.packed_mode ? req.value[15:8] : run_idx;
				op_d.idx1        = req.value[7:0];
				op_d.word        = run_len;
				op_d.skip        = cfg.masked && (run_idx == 8'd0);
			end
			prid_pkg::REQ_RESTART: begin
				op_d.kind = prid_pkg::OP_RESTART;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= known;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_d;
		end
	end

	a_stall_holds_op: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1)
		else $error("intake stalls with no op held");

endmodule

// File: rtl/prid_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prid_queue
// short op queue between intake and execution
// ----------------------------------------------------------------------------
module prid_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  prid_pkg::op_t push_op,
	output logic          full,
	input  logic          pop,
	output prid_pkg::op_t head,
	output logic          empty
);

	localparam int QAW = (prid_pkg::QUEUE_DEPTH > 1) ? $clog2(prid_pkg::QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(prid_pkg::QUEUE_DEPTH + 1);

	prid_pkg::op_t  fifo_q [prid_pkg::QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign full  = (count_q == QCW'(prid_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(prid_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(prid_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_op;
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty op queue");

endmodule

// File: rtl/prid_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prid_div
// radix-2 restoring divider for the raster position wrap
// ----------------------------------------------------------------------------
module prid_div #(
	parameter int DW = 17,
	parameter int WW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [WW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] quotient,
	output logic [WW-1:0] remainder
);

	localparam int NCW = $clog2(DW + 1);

	logic [DW-1:0]  dvd_q;
	logic [WW-1:0]  dvs_q;
	logic [WW-1:0]  rem_q;
	logic [NCW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [WW:0]    shifted;
	logic [WW:0]    trial;
	logic           fits;

	assign shifted   = {rem_q, dvd_q[DW-1]};
	assign trial     = shifted - {1'b0, dvs_q};
	assign fits      = (shifted >= {1'b0, dvs_q});
	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= NCW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - NCW'(1);
			if (cnt_q == NCW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// one quotient bit per cycle, shifted in at the bottom of the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial[WW-1:0] : shifted[WW-1:0];
			dvd_q <= {dvd_q[DW-2:0], fits};
		end
	end

	a_no_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

// File: rtl/prid_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prid_back
// op execution: palette memory, raster position and span output register
// ----------------------------------------------------------------------------
module prid_back #(
	parameter int PALETTE_DEPTH = prid_pkg::PALETTE_DEPTH_DEF,
	parameter int MAX_WIDTH     = prid_pkg::MAX_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  prid_pkg::cfg_t  cfg,
	input  logic            empty,
	input  prid_pkg::op_t   head,
	output logic            pop,
	output logic            span_valid,
	input  logic            span_stall,
	output prid_pkg::span_t span
);

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int DW = ((CW > 16) ? CW : 16) + 1;
	localparam int XW = ((CW > 10) ? CW : 10) + 1;
	localparam int RW = DW + 1;

	prid_pkg::bk_state_t state_q, state_d;

	logic [15:0]     mem [PALETTE_DEPTH];
	logic [15:0]     rd_q;
	logic            rd_oor_q;
	logic [15:0]     pal_color;
	logic            mem_we;
	logic            mem_re;
	logic [7:0]      rd_idx;
	logic            rd_oor;
	logic            wr_oor;

	prid_pkg::op_t   op_q;
	logic            half_q;
	logic [15:0]     color0_q;
	logic [CW-1:0]   col_q;
	logic [10:0]     row_q;
	logic            col_past;

	logic            take_op, grab_c0, half_set, step, pos_clear, pos_div;
	logic            div_start, div_busy, div_done;
	logic [DW-1:0]   div_dvd;
	logic [DW-1:0]   div_q;
	logic [WW-1:0]   div_r;
	logic [WW-1:0]   eff_w;

	logic            span_valid_q;
	prid_pkg::span_t span_q, span_d;
	logic            span_free, span_load;
	logic            e0, e1, want;
	logic [15:0]     c_emit;
	logic            last_emit;
	logic [15:0]     run_emit;
	logic [XW-1:0]   px_sum;
	logic [11:0]     py_sum;
	logic [RW-1:0]   row_sum;

	// width clamped to 1..MAX_WIDTH
	always_comb begin
		if (cfg.image_width == 11'd0) begin
			eff_w = WW'(1);
		end else if (32'(cfg.image_width) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(cfg.image_width);
		end
	end

	// column left at or past a narrowed width needs a full wrap, not a single step
	assign col_past = (WW'(col_q) >= eff_w);

	assign wr_oor    = (32'(head.idx0) >= PALETTE_DEPTH);
	assign rd_oor    = (32'(rd_idx) >= PALETTE_DEPTH);
	assign pal_color = rd_oor_q ? 16'd0 : rd_q;

	// palette memory, one write or one read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[head.idx0[AW-1:0]] <= head.word;
		end
		if (mem_re) begin
			rd_q     <= mem[rd_idx[AW-1:0]];
			rd_oor_q <= rd_oor;
		end
	end

	// span selection for the current emit step
	always_comb begin
		e0 = !(cfg.masked && (color0_q == 16'd0));
		e1 = !(cfg.masked && (pal_color == 16'd0));
		if (op_q.packed_mode) begin
			want      = half_q ? e1 : e0;
			c_emit    = half_q ? pal_color : color0_q;
			last_emit = half_q || !e1;
			run_emit  = 16'd1;
		end else begin
			want      = !op_q.skip;
			c_emit    = pal_color;
			last_emit = 1'b1;
			run_emit  = op_q.word;
		end
		px_sum = XW'(cfg.origin_x) + XW'(col_q);
		py_sum = 12'(cfg.origin_y) + 12'(row_q);
		span_d.color      = c_emit;
		span_d.pixel_x    = (px_sum > XW'(prid_pkg::COORD_MAX))
			? 11'(prid_pkg::COORD_MAX) : px_sum[10:0];
		span_d.pixel_y    = (py_sum > 12'(prid_pkg::COORD_MAX))
			? 11'(prid_pkg::COORD_MAX) : py_sum[10:0];
		span_d.run_length = run_emit;
		span_d.last       = last_emit;
	end

	assign span_free = !span_valid_q || !span_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prid_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		rd_idx    = head.idx0;
		take_op   = 1'b0;
		grab_c0   = 1'b0;
		half_set  = 1'b0;
		step      = 1'b0;
		pos_clear = 1'b0;
		pos_div   = 1'b0;
		div_start = 1'b0;
		span_load = 1'b0;
		unique case (state_q)
			prid_pkg::BK_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					unique case (head.kind)
						prid_pkg::OP_PAL: begin
							mem_we = !wr_oor;
						end
						prid_pkg::OP_RESTART: begin
							pos_clear = 1'b1;
						end
						prid_pkg::OP_DATA: begin
							mem_re  = 1'b1;
							take_op = 1'b1;
							state_d = head.packed_mode ? prid_pkg::BK_READ1 : prid_pkg::BK_EMIT;
						end
						default: begin
						end
					endcase
				end
			end
			prid_pkg::BK_READ1: begin
				mem_re  = 1'b1;
				rd_idx  = op_q.idx1;
				grab_c0 = 1'b1;
				state_d = prid_pkg::BK_EMIT;
			end
			prid_pkg::BK_EMIT: begin
				if (!want || span_free) begin
					span_load = want;
					if (op_q.packed_mode && !col_past) begin
						step = 1'b1;
						if (half_q) begin
							state_d = prid_pkg::BK_IDLE;
						end else begin
							half_set = 1'b1;
						end
					end else begin
						div_start = 1'b1;
						state_d   = prid_pkg::BK_DIV;
					end
				end
			end
			prid_pkg::BK_DIV: begin
				if (div_done) begin
					pos_div = 1'b1;
					// a packed word goes back for its second pixel
					if (op_q.packed_mode && !half_q) begin
						half_set = 1'b1;
						state_d  = prid_pkg::BK_EMIT;
					end else begin
						state_d = prid_pkg::BK_IDLE;
					end
				end
			end
			default: begin
				state_d = prid_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take_op) begin
			op_q <= head;
		end
		if (take_op) begin
			half_q <= 1'b0;
		end else if (half_set) begin
			half_q <= 1'b1;
		end
		if (grab_c0) begin
			color0_q <= pal_color;
		end
	end

	// packed pixels advance by one, runs by their length
	assign div_dvd = DW'(col_q) + (op_q.packed_mode ? DW'(1) : DW'(op_q.word));

	prid_div #(
		.DW(DW),
		.WW(WW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (eff_w),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q),
		.remainder(div_r)
	);

	assign row_sum = RW'(row_q) + RW'(div_q);

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pos_clear) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if ((WW'(col_q) + WW'(1)) == eff_w) begin
				col_q <= '0;
				row_q <= (row_q == 11'(prid_pkg::COORD_MAX)) ? row_q : row_q + 11'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end else if (pos_div) begin
			col_q <= div_r[CW-1:0];
			row_q <= (row_sum > RW'(prid_pkg::COORD_MAX))
				? 11'(prid_pkg::COORD_MAX) : row_sum[10:0];
		end
	end

	// span output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid_q <= 1'b0;
		end else if (span_load) begin
			span_valid_q <= 1'b1;
		end else if (!span_stall) begin
			span_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (span_load) begin
			span_q <= span_d;
		end
	end

	assign span_valid = span_valid_q;
	assign span       = span_q;

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == prid_pkg::BK_DIV |-> div_busy || div_done)
		else $error("waiting on a divider that is not running");

	a_load_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		span_load |-> state_q == prid_pkg::BK_EMIT && span_free)
		else $error("span loaded outside emit or over a held span");

endmodule

// File: rtl/palette_rle_image_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_rle_image_decoder_core
// palettized image decoder producing rgb565 pixel spans
// ----------------------------------------------------------------------------
//  channel  handshake                  payload           beat
//  req      req_valid / req_stall      prid_pkg::req_t   palette write, data word, restart
//  span     span_valid / span_stall    prid_pkg::span_t  one pixel span
//  cfg      cfg_write                  cfg_index, data   one register write
//
//  palette write and restart: taken in the idle state of the execution unit
//  packed data word: two palette reads, two emit steps
//  a packed step from a column left past a narrowed width takes the divider
//  run data word: one palette read, one emit step, then the bit-serial position divider
//  reset clears position, queue and control; palette contents undefined until written
//  a stalled span holds the emit step; the intake keeps filling the op queue
// ----------------------------------------------------------------------------
module palette_rle_image_decoder_core #(
	parameter int PALETTE_DEPTH = prid_pkg::PALETTE_DEPTH_DEF,
	parameter int MAX_WIDTH     = prid_pkg::MAX_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  prid_pkg::req_t  req,
	output logic            span_valid,
	input  logic            span_stall,
	output prid_pkg::span_t span,
	input  logic            cfg_write,
	input  logic [2:0]      cfg_index,
	input  logic [10:0]     cfg_data
);

	prid_pkg::cfg_t cfg_q;

	// front to queue
	logic          push;
	prid_pkg::op_t push_op;
	logic          full;

	// queue to back
	logic          pop;
	logic          empty;
	prid_pkg::op_t head;

	// configuration registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width <= 11'd1;
			cfg_q.index_bits  <= '0;
			cfg_q.masked      <= 1'b0;
			cfg_q.origin_x    <= '0;
			cfg_q.origin_y    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				prid_pkg::CFG_IMAGE_WIDTH:  cfg_q.image_width <= cfg_data;
				// height is accepted but not stored; nothing here uses it
				prid_pkg::CFG_IMAGE_HEIGHT: ;
				prid_pkg::CFG_INDEX_BITS:   cfg_q.index_bits  <= cfg_data[3:0];
				prid_pkg::CFG_MASKED:       cfg_q.masked      <= cfg_data[0];
				prid_pkg::CFG_ORIGIN_X:     cfg_q.origin_x    <= cfg_data[9:0];
				prid_pkg::CFG_ORIGIN_Y:     cfg_q.origin_y    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// intake: classify requests, unpack data words
	prid_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.push     (push),
		.op       (push_op),
		.full     (full)
	);

	// decoupling queue
	prid_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.full   (full),
		.pop    (pop),
		.head   (head),
		.empty  (empty)
	);

	// execution: palette, raster position, spans
	prid_back #(
		.PALETTE_DEPTH(PALETTE_DEPTH),
		.MAX_WIDTH    (MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.span_valid(span_valid),
		.span_stall(span_stall),
		.span      (span)
	);

endmodule

// File: sim/prid_span_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prid_span_checker
// watches the request, span and register channels of the image decoder,
// predicts the spans from its own palette and raster position, and compares
// ----------------------------------------------------------------------------
module prid_span_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_stall,
	input  prid_pkg::req_t  req,
	input  logic            span_valid,
	input  logic            span_stall,
	input  prid_pkg::span_t span,
	input  logic            cfg_write,
	input  logic [2:0]      cfg_index,
	input  logic [10:0]     cfg_data,
	output int              fail_count,
	output int              pending,
	output int              spans_checked
);
	import prid_pkg::*;

	localparam int REPORT_CAP = 150;

	logic [15:0] palette_mem [PALETTE_DEPTH_DEF];
	int          col;
	int          row_pos;
	logic [10:0] width_reg;
	logic [10:0] height_reg;
	logic [3:0]  bits_reg;
	logic        masked_reg;
	logic [9:0]  org_x_reg;
	logic [9:0]  org_y_reg;
	span_t       expected_spans [$];
	span_t       want;
	int          errors;
	int          waiting;
	int          compared;

	assign fail_count    = errors;
	assign pending       = waiting;
	assign spans_checked = compared;

	function automatic logic [10:0] screen_coord(input int v);
		return (v > COORD_MAX) ? 11'(COORD_MAX) : 11'(v);
	endfunction

	// raster advance with wrap at the clamped width, row saturating
	function automatic void step_position(input int run);
		int w;
		int total;
		if (width_reg == 0) begin
			w = 1;
		end else if (width_reg > MAX_WIDTH_DEF) begin
			w = MAX_WIDTH_DEF;
		end else begin
			w = int'(width_reg);
		end
		total   = col + run;
		row_pos = row_pos + total / w;
		if (row_pos > COORD_MAX) begin
			row_pos = COORD_MAX;
		end
		col = total % w;
	endfunction

	function automatic void push_span(input logic [15:0] color, input int run);
		span_t s;
		s.color      = color;
		s.pixel_x    = screen_coord(int'(org_x_reg) + col);
		s.pixel_y    = screen_coord(int'(org_y_reg) + row_pos);
		s.run_length = 16'(run);
		s.last       = 1'b0;
		expected_spans.push_back(s);
	endfunction

	function automatic void load_register(input logic [2:0] idx, input logic [10:0] data);
		case (idx)
			CFG_IMAGE_WIDTH:  width_reg  = data;
			CFG_IMAGE_HEIGHT: height_reg = data;
			CFG_INDEX_BITS:   bits_reg   = data[3:0];
			CFG_MASKED:       masked_reg = data[0];
			CFG_ORIGIN_X:     org_x_reg  = data[9:0];
			CFG_ORIGIN_Y:     org_y_reg  = data[9:0];
			default: ;
		endcase
	endfunction

	function automatic void decode_request(input req_t r);
		int          queued_at_entry;
		int          eb;
		int          run;
		logic [7:0]  idx;
		logic [15:0] color;
		span_t       tail;
		queued_at_entry = expected_spans.size();
		case (r.req_type)
			REQ_PALETTE: palette_mem[r.palette_index] = r.value;
			REQ_RESTART: begin
				col     = 0;
				row_pos = 0;
			end
			REQ_DATA: begin
				if (bits_reg == 0) begin
					// two byte indices, high byte first, one pixel each
					for (int i = 0; i < 2; i++) begin
						idx   = (i == 0) ? r.value[15:8] : r.value[7:0];
						color = palette_mem[idx];
						if (!(masked_reg && color == 16'h0000)) begin
							push_span(color, 1);
						end
						step_position(1);
					end
				end else begin
					eb    = (bits_reg > INDEX_BITS_MAX) ? INDEX_BITS_MAX : int'(bits_reg);
					idx   = 8'(r.value & ((16'd1 << eb) - 16'd1));
					run   = int'(r.value >> eb) + 1;
					color = palette_mem[idx];
					if (!(masked_reg && idx == 8'd0)) begin
						push_span(color, run);
					end
					step_position(run);
				end
			end
			default: ;
		endcase
		if (expected_spans.size() > queued_at_entry) begin
			tail      = expected_spans.pop_back();
			tail.last = 1'b1;
			expected_spans.push_back(tail);
		end
	endfunction

	function automatic void compare_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			errors++;
			if (errors <= REPORT_CAP) begin
				$display("%0t: span %s expected 0x%0h got 0x%0h", $time, name, exp_v, got_v);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col        = 0;
			row_pos    = 0;
			width_reg  = 11'd1;
			height_reg = 11'd1;
			bits_reg   = 4'd0;
			masked_reg = 1'b0;
			org_x_reg  = 10'd0;
			org_y_reg  = 10'd0;
			expected_spans.delete();
			waiting    = 0;
		end else begin
			if (cfg_write) begin
				load_register(cfg_index, cfg_data);
			end
			if (req_valid && !req_stall) begin
				decode_request(req);
			end
			if (span_valid && !span_stall) begin
				if (expected_spans.size() == 0) begin
					errors++;
					if (errors <= REPORT_CAP) begin
						$display("%0t: span expected none got color 0x%0h x %0d y %0d run %0d",
							$time, span.color, span.pixel_x, span.pixel_y, span.run_length);
					end
				end else begin
					want = expected_spans.pop_front();
					compare_field("color", want.color, span.color);
					compare_field("pixel_x", want.pixel_x, span.pixel_x);
					compare_field("pixel_y", want.pixel_y, span.pixel_y);
					compare_field("run_length", want.run_length, span.run_length);
					compare_field("last", want.last, span.last);
					compared++;
				end
			end
			waiting = expected_spans.size();
		end
	end

	initial begin
		errors   = 0;
		waiting  = 0;
		compared = 0;
	end

endmodule

// File: sim/palette_rle_image_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_rle_image_decoder_core_tb
// drives palette loads, data words, restarts and junk requests into the
// decoder under several register settings, with random gaps and back-pressure,
// while the span checker predicts and compares every span
// ----------------------------------------------------------------------------
module palette_rle_image_decoder_core_tb;
	import prid_pkg::*;

	localparam int RESET_CYCLES  = 2;
	localparam int RANDOM_ITEMS  = 1250;
	localparam int RANDOM_PHASES = 12;
	localparam int CALM_PHASE    = 5;    // phase run with no gaps and no stalls
	localparam int WIDE_PHASE    = 4;    // phase run with both origins at their top
	localparam int IDLE_PERCENT  = 30;
	localparam int DRAIN_CYCLES  = 200;  // covers a full op queue of run words
	localparam int QUIET_LIMIT   = 4000;

	// request code the block ignores
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        req_valid  = 1'b0;
	logic        req_stall;
	req_t        req        = '0;
	logic        span_valid;
	logic        span_stall = 1'b0;
	span_t       span;
	logic        cfg_write  = 1'b0;
	logic [2:0]  cfg_index  = '0;
	logic [10:0] cfg_data   = '0;

	logic        calm       = 1'b0;
	logic        written [PALETTE_DEPTH_DEF];  // palette entries loaded so far
	int          fail_count;
	int          pending;
	int          spans_checked;
	int          beats_sent    = 0;
	int          words_sent    = 0;
	int          settings_used = 0;
	int          quiet_cycles  = 0;

	always #1 clk = ~clk;

	palette_rle_image_decoder_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.span_valid (span_valid),
		.span_stall (span_stall),
		.span       (span),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	prid_span_checker span_watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.span_valid    (span_valid),
		.span_stall    (span_stall),
		.span          (span),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.spans_checked (spans_checked)
	);

	// span side back-pressure, off during the calm phase
	always @(negedge clk) begin
		span_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
	end

	// watchdog: any beat or register write restarts the count
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (span_valid && !span_stall) || cfg_write) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat for %0d cycles, giving up", $time, QUIET_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// present one request beat and hold it until taken; called and returns at a falling edge
	task automatic send(input logic [1:0] kind, input logic [7:0] pidx, input logic [15:0] val);
		// random gaps before the beat
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{req_type: kind, palette_index: pidx, value: val};
		if (kind == REQ_PALETTE) begin
			written[pidx] = 1'b1;
		end
		beats_sent++;
		if (kind == REQ_DATA) begin
			words_sent++;
		end
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic put_register(input logic [2:0] idx, input int data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 11'(data);
		@(negedge clk);
	endtask

	// full register set, only while the block is idle
	task automatic load_settings(input int width, input int height, input int bits,
			input int mask, input int ox, input int oy);
		put_register(CFG_IMAGE_WIDTH, width);
		put_register(CFG_IMAGE_HEIGHT, height);
		put_register(CFG_INDEX_BITS, bits);
		put_register(CFG_MASKED, mask);
		put_register(CFG_ORIGIN_X, ox);
		put_register(CFG_ORIGIN_Y, oy);
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	// drop valid, wait for every predicted span, then let queued no-span ops finish
	task automatic settle();
		req_valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// a palette index in 0..hi that has been loaded; entry 0 is always loaded
	function automatic logic [7:0] pick_loaded(input int hi);
		int idx;
		do idx = $urandom_range(0, hi); while (!written[idx]);
		return 8'(idx);
	endfunction

	// mostly data words, the rest palette loads, restarts and junk requests
	task automatic send_random(input int bits);
		int roll;
		int eb;
		int count;
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			if (bits == 0) begin
				send(REQ_DATA, 8'($urandom), {pick_loaded(255), pick_loaded(255)});
			end else begin
				eb = (bits > INDEX_BITS_MAX) ? INDEX_BITS_MAX : bits;
				// half short runs so rows move slowly, half over the full count range
				if ($urandom_range(0, 1) == 1) begin
					count = $urandom_range(0, (1 << (16 - eb)) - 1);
				end else begin
					count = $urandom_range(0, 7);
				end
				send(REQ_DATA, 8'($urandom), 16'((count << eb) | pick_loaded((1 << eb) - 1)));
			end
		end else if (roll < 85) begin
			// a quarter of the loads make a transparent color
			send(REQ_PALETTE, 8'($urandom), ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom));
		end else if (roll < 94) begin
			send(REQ_RESTART, 8'($urandom), 16'($urandom));
		end else begin
			send(REQ_UNUSED, 8'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		int width;
		int bits;
		foreach (written[i]) written[i] = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// packed pairs, odd width, masked, origins at their top
		load_settings(3, 1, 0, 1, 1023, 1023);
		send(REQ_PALETTE, 8'd0, 16'h0000);
		send(REQ_PALETTE, 8'd255, 16'hffff);
		send(REQ_PALETTE, 8'd1, 16'h8001);
		send(REQ_PALETTE, 8'd170, 16'h0000);         // transparent color behind a nonzero index
		send(REQ_DATA, 8'hff, {8'd0, 8'd255});       // first pixel skipped, second shown
		send(REQ_DATA, 8'h00, {8'd255, 8'd1});       // two one-pixel spans, not merged
		send(REQ_DATA, 8'h00, {8'd170, 8'd0});       // both transparent, position still moves
		send(REQ_RESTART, 8'hff, 16'hffff);
		send(REQ_UNUSED, 8'h55, 16'h1234);           // ignored, no span
		send(REQ_DATA, 8'h00, {8'd1, 8'd255});
		settle();

		// one-bit index, width one: the longest run drives the row into saturation
		load_settings(1, 2047, 1, 0, 0, 1023);
		send(REQ_DATA, 8'h00, 16'hffff);
		send(REQ_DATA, 8'h00, 16'h0000);
		send(REQ_RESTART, 8'h00, 16'h0000);
		send(REQ_DATA, 8'h00, 16'h0002);
		settle();

		// width zero, index width beyond eight, masked run on index zero
		load_settings(0, 1024, 12, 1, 512, 0);
		send(REQ_DATA, 8'h00, 16'hff00);
		send(REQ_DATA, 8'h00, 16'h00ff);
		send(REQ_DATA, 8'h00, 16'hffff);
		settle();

		// width above the maximum, full eight-bit index
		load_settings(2047, 1, 8, 0, 1023, 0);
		send(REQ_DATA, 8'h00, 16'h05ff);
		send(REQ_DATA, 8'h00, 16'hff01);
		settle();

		// random phases, each under its own register setting
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 8)
				0: width = 0;
				1: width = 1;
				2: width = 2;
				3: width = 2 * $urandom_range(1, 31) + 1;
				4: width = 2 * $urandom_range(1, 32);
				5: width = MAX_WIDTH_DEF;
				6: width = $urandom_range(MAX_WIDTH_DEF + 1, 2047);
				default: width = $urandom_range(1, MAX_WIDTH_DEF);
			endcase
			bits = (p % 3 == 0) ? 0 : $urandom_range(1, 15);
			calm = (p == CALM_PHASE);
			load_settings(width, $urandom_range(0, 2047), bits, p % 2,
				(p == WIDE_PHASE) ? 1023 : $urandom_range(0, 1023),
				(p == WIDE_PHASE) ? 1023 : $urandom_range(0, 1023));
			for (int k = 0; k < RANDOM_ITEMS / RANDOM_PHASES; k++) begin
				send_random(bits);
			end
			settle();
		end
		calm = 1'b0;

		$display("run covered %0d request beats (%0d data words) over %0d register settings",
			beats_sent, words_sent, settings_used);
		$display("%0d spans compared, %0d mismatches", spans_checked, fail_count);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
